@@ design/rc_frame_packet_generator_assert.svh @@
`ifndef RC_FRAME_PACKET_GENERATOR_ASSERT_SVH
`define RC_FRAME_PACKET_GENERATOR_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define RFPG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define RFPG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rfpg_pkg.sv @@
package rfpg_pkg;

  localparam int CHANNEL_FULL_SCALE = 10000;
  localparam int HOP_COUNT          = 20;
  localparam int FAILSAFE_PERIOD    = 17;

  localparam int NumLanes  = 4;
  localparam int LaneDepth = 4;
  localparam int ValW      = 16;
  localparam int PktLen    = 10;
  localparam int HopSlots  = 20;
  localparam int HopChunk  = 7;
  localparam int HopBits   = 8 * HopSlots;
  localparam int AddrBits  = 40;
  localparam int AddrBytes = 5;

  // pulse conversion
  localparam longint PulseSpanNs = 500000;
  localparam longint PulseMidNs  = 1500 * 1000;
  localparam longint PulseCapNs  = 49151 * 1000;
  localparam longint TimerDiv    = 3000 / 4;
  localparam logic [ValW-1:0] TimerMax = 16'hffff;

  localparam longint PulseGain = PulseSpanNs / CHANNEL_FULL_SCALE;
  localparam longint PulseRem  = PulseSpanNs % CHANNEL_FULL_SCALE;
  localparam int GainW   = $clog2(PulseGain + 1);
  localparam int ScaledW = ValW + GainW;
  localparam int RemW    = $clog2(CHANNEL_FULL_SCALE + 1);
  localparam int FracW   = ValW + RemW;
  localparam int FsW     = $clog2(CHANNEL_FULL_SCALE);
  localparam int RecipShift = FracW + FsW;
  localparam int RecipW  = FracW + 2;
  localparam int FracProdW = FracW + RecipW;
  localparam longint unsigned PulseRecip =
    ((64'd1 << RecipShift) + CHANNEL_FULL_SCALE - 1) / CHANNEL_FULL_SCALE;

  localparam int MagW   = ScaledW + 1;
  localparam int SumW   = MagW + 1;
  localparam int PulseW = $clog2(PulseCapNs + 1);
  localparam int TimerShift = PulseW + $clog2(TimerDiv);
  localparam int TimerRecipW = TimerShift - $clog2(TimerDiv) + 2;
  localparam int TimerProdW = PulseW + TimerRecipW;
  localparam longint unsigned TimerRecip =
    ((64'd1 << TimerShift) + TimerDiv - 1) / TimerDiv;

  // packet constants
  localparam logic [7:0] IdStick   = 8'h55;
  localparam logic [7:0] IdStick4  = 8'h56;
  localparam logic [7:0] IdFs      = 8'haa;
  localparam logic [7:0] IdFs4     = 8'hab;
  localparam logic [7:0] TailStick = 8'h67;
  localparam logic [7:0] TailFs    = 8'h5a;
  localparam logic [7:0] BindHead  = 8'hff;
  localparam logic [7:0] BindRf    = 8'd81;

  localparam int EopBit = 2;

  typedef enum logic [1:0] {
    KindStick    = 2'd0,
    KindFailsafe = 2'd1,
    KindBind     = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    RegStationAddr = 3'd0,
    RegHopA        = 3'd1,
    RegHopB        = 3'd2,
    RegHopC        = 3'd3,
    RegFourCh      = 3'd4,
    RegBindEn      = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [AddrBits-1:0] addr;
    logic [HopBits-1:0]  hop;
    logic                four;
    logic                bind_en;
  } cfg_t;

  typedef struct packed {
    logic       fs;
    logic [7:0] rf;
  } ctrl_t;

  typedef struct packed {
    logic [NumLanes-1:0][ValW-1:0] data;
    ctrl_t                         ctl;
  } frame_t;

  function automatic logic [7:0] hop_byte(input logic [HopBits-1:0] tab,
                                          input logic [4:0] idx);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < HopSlots; i++) begin
      if (idx == 5'(i)) r = tab[8*i +: 8];
    end
    return r;
  endfunction

endpackage

@@ design/rfpg_lane.sv @@
module rfpg_lane (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [rfpg_pkg::ValW-1:0]  value_i,
  output logic [rfpg_pkg::ValW-1:0]         data_o
);

  logic [rfpg_pkg::ValW-1:0] abs_val;

  logic                           neg1_q, neg2_q;
  logic [rfpg_pkg::ScaledW-1:0]   gain1_q, gain2_q;
  logic [rfpg_pkg::FracW-1:0]     frac1_q;
  logic [rfpg_pkg::ValW-1:0]      quo2_q;
  logic [rfpg_pkg::PulseW-1:0]    pulse_d, pulse_q;
  logic [rfpg_pkg::ValW-1:0]      timer_q;

  logic [rfpg_pkg::FracProdW-1:0]  frac_prod;
  logic [rfpg_pkg::MagW-1:0]       mag;
  logic [rfpg_pkg::SumW-1:0]       sum;
  logic [rfpg_pkg::TimerProdW-1:0] timer_prod;

  assign abs_val = value_i[rfpg_pkg::ValW-1] ? rfpg_pkg::ValW'(-value_i)
                                             : rfpg_pkg::ValW'(value_i);

  // fractional part of the gain through a reciprocal
  assign frac_prod = rfpg_pkg::FracProdW'(frac1_q) *
                     rfpg_pkg::FracProdW'(rfpg_pkg::PulseRecip);

  assign mag = rfpg_pkg::MagW'(gain2_q) + rfpg_pkg::MagW'(quo2_q);
  assign sum = rfpg_pkg::SumW'(mag) + rfpg_pkg::SumW'(rfpg_pkg::PulseMidNs);

  always_comb begin
    if (neg2_q) begin
      if (rfpg_pkg::SumW'(mag) >= rfpg_pkg::SumW'(rfpg_pkg::PulseMidNs)) begin
        pulse_d = '0;
      end else begin
        pulse_d = rfpg_pkg::PulseW'(rfpg_pkg::SumW'(rfpg_pkg::PulseMidNs) -
                                    rfpg_pkg::SumW'(mag));
      end
    end else if (64'(sum) > 64'(rfpg_pkg::PulseCapNs)) begin
      pulse_d = rfpg_pkg::PulseW'(rfpg_pkg::PulseCapNs);
    end else begin
      pulse_d = rfpg_pkg::PulseW'(sum);
    end
  end

  assign timer_prod = rfpg_pkg::TimerProdW'(pulse_q) *
                      rfpg_pkg::TimerProdW'(rfpg_pkg::TimerRecip);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q  <= value_i[rfpg_pkg::ValW-1];
      gain1_q <= rfpg_pkg::ScaledW'(abs_val) * rfpg_pkg::ScaledW'(rfpg_pkg::PulseGain);
      frac1_q <= rfpg_pkg::FracW'(abs_val) * rfpg_pkg::FracW'(rfpg_pkg::PulseRem);
      neg2_q  <= neg1_q;
      gain2_q <= gain1_q;
      quo2_q  <= frac_prod[rfpg_pkg::RecipShift +: rfpg_pkg::ValW];
      pulse_q <= pulse_d;
      timer_q <= timer_prod[rfpg_pkg::TimerShift +: rfpg_pkg::ValW];
    end
  end

  assign data_o = rfpg_pkg::TimerMax - timer_q;

endmodule

@@ design/rfpg_serializer.sv @@
`include "rc_frame_packet_generator_assert.svh"

module rfpg_serializer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rfpg_pkg::cfg_t         cfg_i,
  input  logic                   frame_valid_i,
  input  rfpg_pkg::frame_t       frame_i,
  output logic                   frame_ready_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [23:0]            m_axis_tdata_o,  // packet_byte, byte_position, radio_channel
  output logic [2:0]             m_axis_tuser_o,  // packet_kind, end_of_packet
  output logic                   m_axis_tlast_o   // end_of_frame
);

  typedef enum logic [3:0] {
    SeqIdle   = 4'b0001,
    SeqFirst  = 4'b0010,
    SeqRepeat = 4'b0100,
    SeqBind   = 4'b1000
  } seq_e;

  seq_e             state_q;
  logic [3:0]       pos_q;
  logic [1:0]       bph_q;
  rfpg_pkg::frame_t frm_q;

  logic        m_valid_q, m_last_q;
  logic [23:0] m_data_q;
  logic [2:0]  m_user_q;

  logic              emit, pkt_end, frame_last, take;
  logic [7:0]        byte_d, rf_d;
  rfpg_pkg::kind_e   kind_d;
  logic [10:0]       addr_sum;
  logic [1:0]        bind_row;
  logic [4:0]        hop_idx;
  logic [7:0]        id_stick, id_fs;

  assign emit       = (state_q != SeqIdle) && (!m_valid_q || m_axis_tready_i);
  assign pkt_end    = pos_q == 4'(rfpg_pkg::PktLen - 1);
  assign frame_last = pkt_end &&
                      (state_q == SeqBind || (state_q == SeqRepeat && !cfg_i.bind_en));
  assign take       = (state_q == SeqIdle) || (emit && frame_last);
  assign frame_ready_o = take;

  assign id_stick = cfg_i.four ? rfpg_pkg::IdStick4 : rfpg_pkg::IdStick;
  assign id_fs    = cfg_i.four ? rfpg_pkg::IdFs4 : rfpg_pkg::IdFs;
  assign bind_row = bph_q - 2'd1;
  assign hop_idx  = 5'(bind_row) * 5'(rfpg_pkg::HopChunk) + (5'(pos_q) - 5'd3);

  always_comb begin
    addr_sum = '0;
    for (int i = 0; i < rfpg_pkg::AddrBytes; i++) begin
      addr_sum = addr_sum + 11'(cfg_i.addr[8*i +: 8]);
    end
  end

  always_comb begin
    byte_d = '0;
    if (state_q == SeqBind) begin
      kind_d = rfpg_pkg::KindBind;
      rf_d   = rfpg_pkg::BindRf;
      if (bph_q == 2'd0) begin
        case (pos_q)
          4'd0: byte_d = rfpg_pkg::BindHead;
          4'd1: byte_d = id_fs;
          4'd2: byte_d = id_stick;
          default: begin
            for (int i = 0; i < rfpg_pkg::AddrBytes; i++) begin
              if (pos_q == 4'(i + 3)) byte_d = cfg_i.addr[8*i +: 8];
            end
          end
        endcase
      end else begin
        case (pos_q)
          4'd0:    byte_d = addr_sum[7:0];
          4'd1:    byte_d = 8'(addr_sum[10:8]);
          4'd2:    byte_d = 8'(bind_row);
          default: byte_d = rfpg_pkg::hop_byte(cfg_i.hop, hop_idx);
        endcase
      end
    end else begin
      kind_d = frm_q.ctl.fs ? rfpg_pkg::KindFailsafe : rfpg_pkg::KindStick;
      rf_d   = frm_q.ctl.rf;
      case (pos_q)
        4'd0: byte_d = frm_q.data[0][7:0];
        4'd1: byte_d = frm_q.data[0][15:8];
        4'd2: byte_d = frm_q.data[1][7:0];
        4'd3: byte_d = frm_q.data[1][15:8];
        4'd4: byte_d = frm_q.data[2][7:0];
        4'd5: byte_d = frm_q.data[2][15:8];
        4'd6: byte_d = cfg_i.four ? frm_q.data[3][7:0] : 8'd0;
        4'd7: byte_d = frm_q.ctl.fs ? id_fs : id_stick;
        4'd8: byte_d = frm_q.ctl.fs ? rfpg_pkg::TailFs : rfpg_pkg::TailStick;
        4'd9: byte_d = cfg_i.four ? frm_q.data[3][15:8] : 8'd0;
        default: byte_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SeqIdle;
      pos_q     <= '0;
      bph_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (take) begin
        state_q <= frame_valid_i ? SeqFirst : SeqIdle;
        pos_q   <= '0;
      end else if (emit) begin
        if (pkt_end) begin
          pos_q   <= '0;
          state_q <= (state_q == SeqFirst) ? SeqRepeat : SeqBind;
        end else begin
          pos_q <= pos_q + 4'd1;
        end
      end
      if (emit && state_q == SeqBind && pkt_end) begin
        bph_q <= bph_q + 2'd1;
      end
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && frame_valid_i) begin
      frm_q <= frame_i;
    end
    if (emit) begin
      m_data_q <= {4'd0, rf_d, pos_q, byte_d};
      m_user_q <= {pkt_end, kind_d};
      m_last_q <= frame_last;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

  `RFPG_ASSERT_NXT(a_bind_rotates, emit && state_q == SeqBind && pkt_end, bph_q == $past(bph_q) + 2'd1, "bind phase did not advance")
  `RFPG_ASSERT_IMP(a_last_ends_packet, m_valid_q && m_last_q, m_user_q[rfpg_pkg::EopBit], "frame end not on packet end")
  `RFPG_ASSERT_IMP(a_bind_channel, m_valid_q && m_user_q[1:0] == rfpg_pkg::KindBind, m_data_q[19:12] == rfpg_pkg::BindRf, "bind byte off bind channel")
  `RFPG_ASSERT_IMP(a_take_idle_or_end, take && frame_valid_i && state_q != SeqIdle, emit && frame_last, "frame loaded mid-frame")

endmodule

@@ design/rc_frame_packet_generator.sv @@
// a frame passes the lane pipeline, then the serializer frame and byte registers
// one byte per cycle while tready is high; 20 bytes per frame, 30 with binding on
// the byte serializer sets the rate; the conversion lanes take the next frame
// while the current one is still being sent
// reset: rst_ni low clears config registers, hop and failsafe counters, bind
// phase and valid flags; datapath registers keep their contents
module rc_frame_packet_generator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,   // channel_one..four, failsafe_one..four
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [23:0]  m_axis_tdata_o,   // packet_byte, byte_position, radio_channel
  output logic [2:0]   m_axis_tuser_o,   // packet_kind, end_of_packet
  output logic         m_axis_tlast_o,   // end_of_frame
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [55:0]  cfg_data_i
);

  logic [39:0] addr_q;
  logic [55:0] hop_a_q, hop_b_q;
  logic [47:0] hop_c_q;
  logic        four_q, bind_q;

  logic [4:0] hop_q, hop_next;
  logic [4:0] fsph_q, fsph_next;
  logic       fs_next;

  logic [rfpg_pkg::LaneDepth-1:0] vld_q;
  rfpg_pkg::ctrl_t                ctl_q [rfpg_pkg::LaneDepth];
  rfpg_pkg::ctrl_t                ctl_d;
  rfpg_pkg::cfg_t                 cfg;
  rfpg_pkg::frame_t               frame;

  logic pipe_en, in_acc, frame_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q  <= '0;
      hop_a_q <= '0;
      hop_b_q <= '0;
      hop_c_q <= '0;
      four_q  <= 1'b0;
      bind_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (rfpg_pkg::cfg_reg_e'(cfg_index_i))
        rfpg_pkg::RegStationAddr: addr_q  <= cfg_data_i[39:0];
        rfpg_pkg::RegHopA:        hop_a_q <= cfg_data_i;
        rfpg_pkg::RegHopB:        hop_b_q <= cfg_data_i;
        rfpg_pkg::RegHopC:        hop_c_q <= cfg_data_i[47:0];
        rfpg_pkg::RegFourCh:      four_q  <= cfg_data_i[0];
        rfpg_pkg::RegBindEn:      bind_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg.addr    = addr_q;
  assign cfg.hop     = {hop_c_q, hop_b_q, hop_a_q};
  assign cfg.four    = four_q;
  assign cfg.bind_en = bind_q;

  assign pipe_en         = !vld_q[rfpg_pkg::LaneDepth-1] || frame_ready;
  assign s_axis_tready_o = pipe_en;
  assign in_acc          = s_axis_tvalid_i && pipe_en;

  assign hop_next  = (hop_q == 5'(rfpg_pkg::HOP_COUNT - 1)) ? 5'd0 : hop_q + 5'd1;
  assign fsph_next = (fsph_q == 5'(rfpg_pkg::FAILSAFE_PERIOD - 1)) ? 5'd0 : fsph_q + 5'd1;
  assign fs_next   = fsph_next == 5'd0;

  assign ctl_d.fs = fs_next;
  assign ctl_d.rf = rfpg_pkg::hop_byte(cfg.hop, hop_next);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_q  <= '0;
      fsph_q <= '0;
      vld_q  <= '0;
    end else begin
      if (in_acc) begin
        hop_q  <= hop_next;
        fsph_q <= fsph_next;
      end
      if (pipe_en) begin
        vld_q <= {vld_q[rfpg_pkg::LaneDepth-2:0], in_acc};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ctl_q[0] <= ctl_d;
      for (int i = 1; i < rfpg_pkg::LaneDepth; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  for (genvar k = 0; k < rfpg_pkg::NumLanes; k++) begin : g_lane
    logic signed [rfpg_pkg::ValW-1:0] lane_in;

    assign lane_in = fs_next
      ? $signed(s_axis_tdata_i[rfpg_pkg::ValW*(k+rfpg_pkg::NumLanes) +: rfpg_pkg::ValW])
      : $signed(s_axis_tdata_i[rfpg_pkg::ValW*k +: rfpg_pkg::ValW]);

    rfpg_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (pipe_en),
      .value_i (lane_in),
      .data_o  (frame.data[k])
    );
  end

  assign frame.ctl = ctl_q[rfpg_pkg::LaneDepth-1];

  rfpg_serializer u_ser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .frame_valid_i   (vld_q[rfpg_pkg::LaneDepth-1]),
    .frame_i         (frame),
    .frame_ready_o   (frame_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

@@ verif/testbench.sv @@
module testbench;
  import rfpg_pkg::*;

  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;
  localparam int WatchdogLimit = 3000;
  localparam int ReportLimit = 30;

  typedef struct packed {
    logic [7:0] value;
    logic [3:0] pos;
    kind_e      kind;
    logic [7:0] rf;
    logic       eop;
    logic       eof;
  } radio_byte_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [23:0]  m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;
  logic         m_axis_tlast_o;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [55:0]  cfg_data_i = '0;

  rc_frame_packet_generator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // generator state mirrored here
  logic [39:0] station = '0;
  logic [7:0]  hop_ch [HopSlots];
  logic        four_ch = 1'b0;
  logic        bind_on = 1'b0;
  logic [4:0]  hop_pos = '0;
  logic [4:0]  fail_phase = '0;
  logic [1:0]  bind_step = '0;

  logic [127:0] frames_pending [$];
  radio_byte_t  radio_bytes_due [$];

  int corner_values [12] = '{-32768, 32767, 0, -1, 1, 10000, -10000, -30000, -30001,
                             29999, -12345, 23130};

  bit failed = 1'b0;
  bit quiet = 1'b0;
  bit in_fire = 1'b0;
  bit cfg_fire = 1'b0;
  int in_hold = 0;
  int out_hold = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int frames_queued = 0;
  int frames_accepted = 0;
  int failsafe_frames = 0;
  int bind_packets = 0;
  int bytes_checked = 0;

  initial begin
    foreach (hop_ch[i]) hop_ch[i] = '0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [55:0] rand56();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[55:0];
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2, 3: return 16'(int'($urandom_range(0, 20000)) - 10000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [127:0] random_frame();
    logic [127:0] f;
    for (int k = 0; k < 8; k++) f[16*k +: 16] = rand_value();
    return f;
  endfunction

  function automatic logic [127:0] corner_frame(input int n);
    logic [127:0] f;
    for (int k = 0; k < 8; k++) f[16*k +: 16] = 16'(corner_values[(n + 3 * k) % 12]);
    return f;
  endfunction

  // stick value to receiver timer word
  function automatic logic [15:0] timer_word(input logic signed [15:0] v);
    longint p;
    p = longint'(v) * PulseSpanNs / CHANNEL_FULL_SCALE + PulseMidNs;
    if (p < 0) p = 0;
    if (p > PulseCapNs) p = PulseCapNs;
    return TimerMax - 16'(p * 4 / 3000);
  endfunction

  task automatic apply_write(input logic [2:0] idx, input logic [55:0] data);
    case (idx)
      RegStationAddr: station = data[39:0];
      RegHopA: for (int i = 0; i < 7; i++) hop_ch[i] = data[8*i +: 8];
      RegHopB: for (int i = 0; i < 7; i++) hop_ch[7 + i] = data[8*i +: 8];
      RegHopC: for (int i = 0; i < 6; i++) hop_ch[14 + i] = data[8*i +: 8];
      RegFourCh: four_ch = data[0];
      RegBindEn: bind_on = data[0];
      default: ;
    endcase
  endtask

  task automatic queue_packet(input logic [9:0][7:0] body, input kind_e kind,
                              input logic [7:0] rf, input logic closes_frame);
    radio_byte_t b;
    for (int i = 0; i < PktLen; i++) begin
      b.value = body[i];
      b.pos = 4'(i);
      b.kind = kind;
      b.rf = rf;
      b.eop = (i == PktLen - 1);
      b.eof = closes_frame && (i == PktLen - 1);
      radio_bytes_due.push_back(b);
    end
  endtask

  task automatic plan_frame(input logic [127:0] raw);
    logic [9:0][7:0] pkt;
    logic [15:0] word;
    logic [15:0] addr_sum;
    logic fs;
    int base;
    int first;
    kind_e kind;
    hop_pos = 5'((hop_pos + 1) % HOP_COUNT);
    fail_phase = 5'((fail_phase + 1) % FAILSAFE_PERIOD);
    fs = (fail_phase == 0);
    base = fs ? 4 : 0;
    kind = fs ? KindFailsafe : KindStick;
    pkt = '0;
    for (int i = 0; i < 3; i++) begin
      word = timer_word(raw[16*(base + i) +: 16]);
      pkt[2*i] = word[7:0];
      pkt[2*i + 1] = word[15:8];
    end
    if (four_ch) begin
      word = timer_word(raw[16*(base + 3) +: 16]);
      pkt[6] = word[7:0];
      pkt[9] = word[15:8];
    end
    if (fs) begin
      pkt[7] = four_ch ? IdFs4 : IdFs;
      pkt[8] = TailFs;
      failsafe_frames++;
    end else begin
      pkt[7] = four_ch ? IdStick4 : IdStick;
      pkt[8] = TailStick;
    end
    queue_packet(pkt, kind, hop_ch[hop_pos], 1'b0);
    queue_packet(pkt, kind, hop_ch[hop_pos], !bind_on);
    if (bind_on) begin
      pkt = '0;
      addr_sum = '0;
      for (int i = 0; i < AddrBytes; i++) addr_sum += 16'(station[8*i +: 8]);
      if (bind_step == 0) begin
        pkt[0] = BindHead;
        pkt[1] = four_ch ? IdFs4 : IdFs;
        pkt[2] = four_ch ? IdStick4 : IdStick;
        for (int i = 0; i < AddrBytes; i++) pkt[3 + i] = station[8*i +: 8];
      end else begin
        first = HopChunk * (int'(bind_step) - 1);
        pkt[0] = addr_sum[7:0];
        pkt[1] = addr_sum[15:8];
        pkt[2] = 8'(int'(bind_step) - 1);
        for (int i = 0; i < HopChunk; i++) begin
          if (first + i < HopSlots) pkt[3 + i] = hop_ch[first + i];
        end
      end
      queue_packet(pkt, KindBind, BindRf, 1'b1);
      bind_step = bind_step + 2'd1;
      bind_packets++;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      failed = 1'b1;
      if (mismatches < ReportLimit)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_byte();
    radio_byte_t want;
    if (radio_bytes_due.size() == 0) begin
      failed = 1'b1;
      $display("%0t: byte transfer with nothing expected, expected none actual %h/%h/%b",
               $time, m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
    end else begin
      want = radio_bytes_due.pop_front();
      check_field("packet_byte", want.value, m_axis_tdata_o[7:0]);
      check_field("byte_position", 8'(want.pos), 8'(m_axis_tdata_o[11:8]));
      check_field("radio_channel", want.rf, m_axis_tdata_o[19:12]);
      check_field("packet_kind", 8'(want.kind), 8'(m_axis_tuser_o[1:0]));
      check_field("end_of_packet", 8'(want.eop), 8'(m_axis_tuser_o[EopBit]));
      check_field("end_of_frame", 8'(want.eof), 8'(m_axis_tlast_o));
      bytes_checked++;
    end
  endtask

  // drive on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || in_fire) begin
        if (in_hold > 0) begin
          in_hold--;
          s_axis_tvalid_i <= 1'b0;
        end else if (frames_pending.size() > 0) begin
          s_axis_tdata_i <= frames_pending.pop_front();
          s_axis_tvalid_i <= 1'b1;
          in_hold = pick_gap();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        out_hold = pick_gap();
      end
    end
  end

  // sample on the rising edge
  always @(posedge clk_i) begin
    in_fire <= s_axis_tvalid_i && s_axis_tready_o;
    cfg_fire <= cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      idle_cycles++;
      if (cfg_valid_i && cfg_ready_o) begin
        apply_write(cfg_index_i, cfg_data_i);
        idle_cycles = 0;
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        plan_frame(s_axis_tdata_i);
        frames_accepted++;
        idle_cycles = 0;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        check_byte();
        idle_cycles = 0;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [55:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(negedge clk_i); while (!cfg_fire);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_mode(input logic [55:0] addr, hop_a, hop_b, hop_c, four, bind_en);
    write_reg(RegStationAddr, addr);
    write_reg(RegHopA, hop_a);
    write_reg(RegHopB, hop_b);
    write_reg(RegHopC, hop_c);
    write_reg(RegFourCh, four);
    write_reg(RegBindEn, bind_en);
  endtask

  task automatic run_frames(input int count, input bit corners);
    for (int i = 0; i < count; i++)
      frames_pending.push_back(corners ? corner_frame(i) : random_frame());
    frames_queued += count;
    do @(negedge clk_i); while (frames_accepted != frames_queued || radio_bytes_due.size() != 0);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // corner values, two-channel, binding on, spare indexes ignored
    set_mode(rand56(), rand56(), rand56(), rand56(), rand56() & ~56'd1, rand56() | 56'd1);
    write_reg(RegSpareLo, rand56());
    write_reg(RegSpareHi, rand56());
    run_frames(20, 1'b1);

    // all-ones tables and address, four-channel, no idling
    quiet = 1'b1;
    set_mode('1, '1, '1, '1, '1, '1);
    run_frames(40, 1'b0);
    quiet = 1'b0;

    set_mode('0, '0, '0, '0, rand56() | 56'd1, rand56() & ~56'd1);
    run_frames(35, 1'b0);

    set_mode(rand56(), rand56(), rand56(), rand56(), '0, '0);
    run_frames(35, 1'b0);

    set_mode(rand56(), rand56(), rand56(), rand56(), 56'd1, 56'd1);
    run_frames(40, 1'b0);

    repeat (20) @(negedge clk_i);
    $display("%0d frames (%0d failsafe), %0d bind packets, %0d bytes checked",
             frames_accepted, failsafe_frames, bind_packets, bytes_checked);
    $display("two- and four-channel modes, binding on and off, zero/ones/random tables");
    if (failed) $display("CHECK FAILED");
    else $display("CHECK OK");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/rfpg_pkg.sv
design/rfpg_lane.sv
design/rfpg_serializer.sv
design/rc_frame_packet_generator.sv
verif/testbench.sv
